// ----- hw/rtl/absc_pkg.sv -----
// Shared types, sizes and codes of the adaptive burst sampling controller.
`default_nettype none

package absc_pkg;

    localparam int SITE_ENTRIES = 256;
    localparam int ADDR_W       = 64;
    localparam int IDX_W        = (SITE_ENTRIES > 1) ? $clog2(SITE_ENTRIES) : 1;
    localparam int TAG_W        = ADDR_W - IDX_W;
    localparam int SKIP_W       = 27;
    localparam int RATE_W       = 17;
    localparam int LEN_W        = 10;
    localparam int CEIL_W       = 14;
    localparam int CNT_W        = 64;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 14;
    localparam int ENTRY_W      = TAG_W + SKIP_W + RATE_W;

    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(100);
    localparam logic [CEIL_W-1:0] CEIL_RESET = CEIL_W'(999);
    localparam logic [3:0]        GROW_MUL   = 4'd10;
    localparam logic [3:0]        GROW_ADD   = 4'd9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BURST_LENGTH = 1'b0,
        CFG_RATE_CEILING = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ALU_GROW,
        ALU_RELOAD,
        ALU_DEC
    } alu_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_GROW,
        S_LOAD,
        S_DEC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SKIP_W-1:0] skip;
        logic [RATE_W-1:0] rate;
    } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/absc_if.sv -----
// Handshake channel interfaces for check words and result words.
`default_nettype none

interface absc_check_if;
    logic                        valid;
    logic                        ready;
    logic [absc_pkg::ADDR_W-1:0] site_address;

    modport source (output valid, output site_address, input ready);
    modport sink   (input valid, input site_address, output ready);
endinterface

interface absc_result_if;
    logic                        valid;
    logic                        ready;
    logic                        in_burst;
    logic                        burst_started;
    logic                        sampling_on;
    logic [absc_pkg::RATE_W-1:0] site_rate;
    logic [absc_pkg::CNT_W-1:0]  total_checks;
    logic [absc_pkg::CNT_W-1:0]  sampled_checks;

    modport source (output valid, output in_burst, output burst_started,
                    output sampling_on, output site_rate, output total_checks,
                    output sampled_checks, input ready);
    modport sink   (input valid, input in_burst, input burst_started,
                    input sampling_on, input site_rate, input total_checks,
                    input sampled_checks, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/adaptive_burst_sampling_controller_unit.sv -----
// Top level of the adaptive burst sampling controller.
//
//   Channel   Dir  Handshake        Word contents
//   check     in   valid / ready    site_address[63:0]
//   result    out  valid / ready    in_burst, burst_started, sampling_on,
//                                   site_rate[16:0], total_checks[63:0],
//                                   sampled_checks[63:0]
//   cfg       in   cfg_we           cfg_index (0 burst_length, 1 rate_ceiling),
//                                   cfg_data[13:0]
//
// A check that lands inside a running burst goes from the accept straight
// to the final state and the result register. Any other check goes through
// accept and table read, tag check, an optional rate growth step, the skip
// reload or decrement with the table write, then the result register. The
// single multiply-add unit and the table's read-modify-write set these steps.
// Reset clears valid bits, burst state and counters and presets the config at
// once; there is no clearing pass. A new check is taken in the idle state
// even while the previous result still waits in the output register; a
// finished word waits in the final state until that register is free.
`default_nettype none

module adaptive_burst_sampling_controller_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    absc_check_if.sink                             check,
    absc_result_if.source                          result,
    input  wire logic                              cfg_we,
    input  wire logic [absc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [absc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers.
    logic [absc_pkg::LEN_W-1:0]  burst_length_reg;
    logic [absc_pkg::CEIL_W-1:0] rate_ceiling_reg;

    // Global burst state and check counters.
    logic                        burst_active_reg;
    logic [absc_pkg::LEN_W-1:0]  burst_left_reg;
    logic [absc_pkg::CNT_W-1:0]  total_reg;
    logic [absc_pkg::CNT_W-1:0]  sampled_reg;

    // Site table: valid bits in flops, the rest of each entry in RAM.
    logic [absc_pkg::SITE_ENTRIES-1:0] site_valid_reg;

    // Per-check working registers.
    absc_pkg::state_t            state_reg;
    absc_pkg::state_t            state_next;
    logic [absc_pkg::IDX_W-1:0]  idx_reg;
    logic [absc_pkg::TAG_W-1:0]  tag_reg;
    logic [absc_pkg::SKIP_W-1:0] skip_reg;
    logic [absc_pkg::RATE_W-1:0] rate_reg;
    logic                        item_in_burst_reg;
    logic                        item_started_reg;

    // Output register.
    logic                        result_valid_reg;
    logic                        out_in_burst_reg;
    logic                        out_started_reg;
    logic                        out_sampling_reg;
    logic [absc_pkg::RATE_W-1:0] out_rate_reg;
    logic [absc_pkg::CNT_W-1:0]  out_total_reg;
    logic [absc_pkg::CNT_W-1:0]  out_sampled_reg;

    // Control decoded from the state.
    logic                        accept;
    logic                        out_load;
    logic                        ram_we;
    absc_pkg::alu_op_t           alu_op;
    logic [absc_pkg::SKIP_W-1:0] alu_operand;
    logic [absc_pkg::SKIP_W-1:0] alu_result;

    // Table lookup results.
    absc_pkg::entry_t            rd_entry;
    absc_pkg::entry_t            wr_entry;
    logic                        hit;
    logic [absc_pkg::SKIP_W-1:0] look_skip;
    logic [absc_pkg::RATE_W-1:0] look_rate;
    logic                        rate_below_ceiling;

    assign accept = check.valid && check.ready;

    // The RAM reads the entry of whatever address stands on the port; the
    // data seen in the lookup state belongs to the check accepted before it.
    absc_ram #(
        .WIDTH (absc_pkg::ENTRY_W),
        .DEPTH (absc_pkg::SITE_ENTRIES)
    ) u_site_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .raddr (check.site_address[absc_pkg::IDX_W-1:0]),
        .rdata (rd_entry)
    );

    absc_alu u_alu (
        .op           (alu_op),
        .operand      (alu_operand),
        .burst_length (burst_length_reg),
        .result       (alu_result)
    );

    // A missing or stale entry behaves as a fresh one with zero skip and rate.
    assign hit       = site_valid_reg[idx_reg] && (rd_entry.tag == tag_reg);
    assign look_skip = hit ? rd_entry.skip : '0;
    assign look_rate = hit ? rd_entry.rate : '0;
    assign rate_below_ceiling =
        (rate_reg < absc_pkg::RATE_W'(rate_ceiling_reg));

    assign wr_entry.tag  = tag_reg;
    assign wr_entry.skip = alu_result;
    assign wr_entry.rate = rate_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            absc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = burst_active_reg ? absc_pkg::S_DONE
                                                  : absc_pkg::S_LOOK;
                end
            end
            absc_pkg::S_LOOK:
            begin
                if (look_skip != '0)
                begin
                    state_next = absc_pkg::S_DEC;
                end
                else if (look_rate < absc_pkg::RATE_W'(rate_ceiling_reg))
                begin
                    state_next = absc_pkg::S_GROW;
                end
                else
                begin
                    state_next = absc_pkg::S_LOAD;
                end
            end
            absc_pkg::S_GROW: state_next = absc_pkg::S_LOAD;
            absc_pkg::S_LOAD: state_next = absc_pkg::S_DONE;
            absc_pkg::S_DEC:  state_next = absc_pkg::S_DONE;
            absc_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = absc_pkg::S_IDLE;
                end
            end
            default: state_next = absc_pkg::S_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb
    begin
        check.ready = 1'b0;
        out_load    = 1'b0;
        ram_we      = 1'b0;
        alu_op      = absc_pkg::ALU_DEC;
        alu_operand = skip_reg;
        unique case (state_reg)
            absc_pkg::S_IDLE:
            begin
                check.ready = 1'b1;
            end
            absc_pkg::S_LOOK:
            begin
            end
            absc_pkg::S_GROW:
            begin
                alu_op      = absc_pkg::ALU_GROW;
                alu_operand = absc_pkg::SKIP_W'(rate_reg);
            end
            absc_pkg::S_LOAD:
            begin
                alu_op      = absc_pkg::ALU_RELOAD;
                alu_operand = absc_pkg::SKIP_W'(rate_reg);
                ram_we      = 1'b1;
            end
            absc_pkg::S_DEC:
            begin
                alu_op      = absc_pkg::ALU_DEC;
                alu_operand = skip_reg;
                ram_we      = 1'b1;
            end
            absc_pkg::S_DONE:
            begin
                out_load = !result_valid_reg || result.ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= absc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_length_reg <= absc_pkg::LEN_RESET;
            rate_ceiling_reg <= absc_pkg::CEIL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (absc_pkg::cfg_index_t'(cfg_index))
                absc_pkg::CFG_BURST_LENGTH:
                    burst_length_reg <= cfg_data[absc_pkg::LEN_W-1:0];
                absc_pkg::CFG_RATE_CEILING:
                    rate_ceiling_reg <= cfg_data[absc_pkg::CEIL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Burst state, counters and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_active_reg  <= 1'b0;
            burst_left_reg    <= '0;
            total_reg         <= '0;
            sampled_reg       <= '0;
            site_valid_reg    <= '0;
            item_in_burst_reg <= 1'b0;
            item_started_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                total_reg         <= total_reg + absc_pkg::CNT_W'(1);
                item_in_burst_reg <= burst_active_reg;
                item_started_reg  <= 1'b0;
                if (burst_active_reg)
                begin
                    sampled_reg <= sampled_reg + absc_pkg::CNT_W'(1);
                    if (burst_left_reg <= absc_pkg::LEN_W'(1))
                    begin
                        burst_left_reg   <= '0;
                        burst_active_reg <= 1'b0;
                    end
                    else
                    begin
                        burst_left_reg <= burst_left_reg - absc_pkg::LEN_W'(1);
                    end
                end
            end
            if (state_reg == absc_pkg::S_LOAD)
            begin
                burst_active_reg <= 1'b1;
                burst_left_reg   <= burst_length_reg;
                item_started_reg <= 1'b1;
            end
            if (ram_we)
            begin
                site_valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg  <= check.site_address[absc_pkg::IDX_W-1:0];
            tag_reg  <= check.site_address[absc_pkg::ADDR_W-1:absc_pkg::IDX_W];
            rate_reg <= '0;
        end
        if (state_reg == absc_pkg::S_LOOK)
        begin
            skip_reg <= look_skip;
            rate_reg <= look_rate;
        end
        if (state_reg == absc_pkg::S_GROW && rate_below_ceiling)
        begin
            rate_reg <= alu_result[absc_pkg::RATE_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_in_burst_reg <= item_in_burst_reg;
            out_started_reg  <= item_started_reg;
            out_sampling_reg <= burst_active_reg;
            out_rate_reg     <= item_in_burst_reg ? '0 : rate_reg;
            out_total_reg    <= total_reg;
            out_sampled_reg  <= sampled_reg;
        end
    end

    assign result.valid          = result_valid_reg;
    assign result.in_burst       = out_in_burst_reg;
    assign result.burst_started  = out_started_reg;
    assign result.sampling_on    = out_sampling_reg;
    assign result.site_rate      = out_rate_reg;
    assign result.total_checks   = out_total_reg;
    assign result.sampled_checks = out_sampled_reg;

    // A check taken while a burst runs never touches the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && burst_active_reg) |=> (state_reg == absc_pkg::S_DONE))
        else $error("in-burst check did not go straight to the result");

    // A check that starts a burst leaves sampling switched on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && item_started_reg) |-> burst_active_reg)
        else $error("burst started without sampling on");

    // Starting a burst and falling inside one exclude each other.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(item_started_reg && item_in_burst_reg))
        else $error("check both inside and starting a burst");

    // The table is written only while a lookup is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ($past(state_reg) == absc_pkg::S_LOOK
                    || $past(state_reg) == absc_pkg::S_GROW))
        else $error("table written outside a lookup");

endmodule

`default_nettype wire

// ----- hw/rtl/absc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module absc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output      logic [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/absc_alu.sv -----
// Shared multiply-add unit: rate growth, skip reload and skip decrement.
`default_nettype none

module absc_alu (
    input  wire absc_pkg::alu_op_t               op,
    input  wire logic [absc_pkg::SKIP_W-1:0]     operand,
    input  wire logic [absc_pkg::LEN_W-1:0]      burst_length,
    output      logic [absc_pkg::SKIP_W-1:0]     result
);

    logic [absc_pkg::LEN_W-1:0]  mul_b;
    logic [absc_pkg::SKIP_W-1:0] add_c;
    logic [absc_pkg::SKIP_W+absc_pkg::LEN_W-1:0] product;

    always_comb
    begin
        unique case (op)
            absc_pkg::ALU_GROW:
            begin
                mul_b = absc_pkg::LEN_W'(absc_pkg::GROW_MUL);
                add_c = absc_pkg::SKIP_W'(absc_pkg::GROW_ADD);
            end
            absc_pkg::ALU_RELOAD:
            begin
                mul_b = burst_length;
                add_c = '0;
            end
            absc_pkg::ALU_DEC:
            begin
                // Adding all ones decrements modulo the counter width.
                mul_b = absc_pkg::LEN_W'(1);
                add_c = '1;
            end
            default:
            begin
                mul_b = '0;
                add_c = '0;
            end
        endcase
    end

    assign product = operand * mul_b;
    assign result  = product[absc_pkg::SKIP_W-1:0] + add_c;

endmodule

`default_nettype wire

// ----- tb/adaptive_burst_sampling_controller_unit_test.sv -----
// Self-checking testbench for the adaptive burst sampling controller unit.
module adaptive_burst_sampling_controller_unit_test;

    // Cycles the result side refuses words during the back-pressure test.
    localparam int HOLD_OFF_CYCLES = 200;
    // Quiet cycles after the last expected word before the block is treated
    // as idle.
    localparam int SETTLE_CYCLES = 8;
    // Run limit in time units, far above the slowest legal run.
    localparam int RUN_LIMIT = 5_000_000;

    // One expected result word.
    typedef struct packed {
        logic                        in_burst;
        logic                        burst_started;
        logic                        sampling_on;
        logic [absc_pkg::RATE_W-1:0] site_rate;
        logic [absc_pkg::CNT_W-1:0]  total_checks;
        logic [absc_pkg::CNT_W-1:0]  sampled_checks;
    } check_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [absc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [absc_pkg::CFG_DATA_W-1:0] cfg_data;

    absc_check_if  check_ch ();
    absc_result_if result_ch ();

    adaptive_burst_sampling_controller_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .check     (check_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Copy of the controller state kept by the testbench. It advances once
    // for every check word the block accepts.
    logic [absc_pkg::LEN_W-1:0]  burst_len_setting;
    logic [absc_pkg::CEIL_W-1:0] ceiling_setting;
    bit                          site_live   [absc_pkg::SITE_ENTRIES];
    logic [absc_pkg::TAG_W-1:0]  site_tags   [absc_pkg::SITE_ENTRIES];
    logic [absc_pkg::SKIP_W-1:0] site_skips  [absc_pkg::SITE_ENTRIES];
    logic [absc_pkg::RATE_W-1:0] site_rates  [absc_pkg::SITE_ENTRIES];
    bit                          burst_running;
    logic [absc_pkg::LEN_W-1:0]  burst_remaining;
    logic [absc_pkg::CNT_W-1:0]  checks_seen;
    logic [absc_pkg::CNT_W-1:0]  checks_sampled;

    // Result words the block still owes, oldest first.
    check_result_t pending_decisions[$];

    int mismatch_count;
    bit idling;
    bit hold_off_req;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Computes the result word of one check and advances the state copy.
    // Outside a burst the site's table entry is looked up (a miss or an empty
    // slot starts a fresh entry with skip count and rate at zero); a skip
    // count at zero grows the rate toward the ceiling, reloads the count with
    // rate times burst length and starts a burst. Inside a burst the table is
    // left alone and the check is only counted as sampled.
    function automatic check_result_t sampling_decision(
        input logic [absc_pkg::ADDR_W-1:0] addr);
        check_result_t               d;
        logic [absc_pkg::IDX_W-1:0]  slot;
        logic [absc_pkg::TAG_W-1:0]  tag;
        int unsigned                 grown;
        d = '0;
        checks_seen = checks_seen + 1'b1;
        if (!burst_running)
        begin
            slot = addr[absc_pkg::IDX_W-1:0];
            tag  = addr[absc_pkg::ADDR_W-1:absc_pkg::IDX_W];
            if (!site_live[slot] || site_tags[slot] != tag)
            begin
                site_live[slot]  = 1'b1;
                site_tags[slot]  = tag;
                site_skips[slot] = '0;
                site_rates[slot] = '0;
            end
            if (site_skips[slot] == '0)
            begin
                grown = site_rates[slot];
                if (grown < ceiling_setting)
                    grown = 10 * (grown + 1) - 1;
                grown            = grown & ((1 << absc_pkg::RATE_W) - 1);
                site_rates[slot] = absc_pkg::RATE_W'(grown);
                site_skips[slot] = absc_pkg::SKIP_W'(grown * burst_len_setting);
                burst_running    = 1'b1;
                burst_remaining  = burst_len_setting;
                d.burst_started  = 1'b1;
            end
            else
            begin
                site_skips[slot] = site_skips[slot] - 1'b1;
            end
            d.site_rate = site_rates[slot];
        end
        else
        begin
            d.in_burst     = 1'b1;
            checks_sampled = checks_sampled + 1'b1;
            // A zero-length burst still covers one check.
            if (burst_remaining <= 1)
            begin
                burst_remaining = '0;
                burst_running   = 1'b0;
            end
            else
            begin
                burst_remaining = burst_remaining - 1'b1;
            end
        end
        d.sampling_on    = burst_running;
        d.total_checks   = checks_seen;
        d.sampled_checks = checks_sampled;
        return d;
    endfunction

    // Offers one check word and records its expected result once accepted.
    // Valid is left high afterwards so that back-to-back words need only one
    // assignment per clock edge; it drops only for an idle gap or at the end
    // of a phase.
    task automatic send_check(input logic [absc_pkg::ADDR_W-1:0] addr);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            check_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        check_ch.valid        <= 1'b1;
        check_ch.site_address <= addr;
        do
            @(posedge clk);
        while (!check_ch.ready);
        pending_decisions.push_back(sampling_decision(addr));
    endtask

    // Stops offering words and waits until the block has handed back every
    // result, then lets it settle so that a register write finds it idle.
    task automatic finish_phase();
        check_ch.valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the burst length, then the rate ceiling. Only the low bits of
    // each data word belong to the register, so the state copy keeps those.
    task automatic set_registers(input logic [absc_pkg::CFG_DATA_W-1:0] len_word,
                                 input logic [absc_pkg::CFG_DATA_W-1:0] ceil_word);
        cfg_we    <= 1'b1;
        cfg_index <= absc_pkg::CFG_BURST_LENGTH;
        cfg_data  <= len_word;
        @(posedge clk);
        cfg_index <= absc_pkg::CFG_RATE_CEILING;
        cfg_data  <= ceil_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        burst_len_setting = len_word[absc_pkg::LEN_W-1:0];
        ceiling_setting   = ceil_word[absc_pkg::CEIL_W-1:0];
    endtask

    // Random checks that mostly revisit a few fixed sites, so skip counts run
    // down and rates grow. The rest is split between addresses that land on
    // the same table slot with another tag (evicting the site) and fully
    // random addresses.
    task automatic run_checks(input int count, input int pool_count, input int noise_pct);
        logic [absc_pkg::ADDR_W-1:0] pool [4];
        logic [absc_pkg::ADDR_W-1:0] addr;
        int                          roll;
        foreach (pool[i])
            pool[i] = {$urandom, $urandom};
        repeat (count)
        begin
            addr = pool[$urandom_range(0, pool_count - 1)];
            roll = $urandom_range(1, 100);
            if (roll <= noise_pct / 2)
                addr = {$urandom, $urandom};
            else if (roll <= noise_pct)
                addr = addr + (absc_pkg::ADDR_W'($urandom_range(1, 3)) << absc_pkg::IDX_W);
            send_check(addr);
        end
    endtask

    // Right after reset, with the reset register values: the first check
    // starts a burst of 100, and the next 100 checks all fall inside it, so
    // the burst is over when this test ends.
    task automatic test_reset_values();
        run_checks(101, 2, 40);
        finish_phase();
    endtask

    // A ceiling of 9 with bursts of one: the site reaches rate 9 on its first
    // check, sits out one burst check and nine skips, and then starts a new
    // burst with its rate held at the ceiling.
    task automatic test_ceiling_hold();
        set_registers(absc_pkg::CFG_DATA_W'(1), absc_pkg::CFG_DATA_W'(9));
        repeat (12) send_check('0);
        finish_phase();
    endtask

    // Address 256 shares slot 0 with address 0 but carries another tag, so
    // each of the two evicts the other and starts from a fresh entry. The
    // all-ones words fall in bursts: the previous test's, then the misses'.
    task automatic test_tag_miss();
        send_check('1);
        send_check(absc_pkg::ADDR_W'(256));
        send_check('1);
        send_check('0);
        send_check('1);
        finish_phase();
    endtask

    // A burst length of zero behaves like one: the burst covers one check
    // and the skip count reloads to zero, so the site starts again at once.
    task automatic test_zero_length();
        set_registers('0, absc_pkg::CFG_DATA_W'(9));
        send_check('1);
        send_check(64'hAAAA_AAAA_AAAA_AAAA);
        send_check('1);
        send_check(64'h5555_5555_5555_5555);
        finish_phase();
    endtask

    // A ceiling of zero keeps the rate at zero and the skip count reload at
    // zero, so a site starts a burst on every check outside one.
    task automatic test_zero_ceiling();
        set_registers(absc_pkg::CFG_DATA_W'(2), '0);
        send_check(64'h8000_0000_0000_0000);
        send_check(64'h0000_0000_0000_0001);
        send_check(64'h7FFF_FFFF_FFFF_FFFE);
        send_check(64'h8000_0000_0000_0000);
        finish_phase();
    endtask

    // Bursts of one and the largest ceiling, above every rate reached here:
    // one busy site climbs through rates 9 and 99 to 999. The burst of two
    // left running by the previous test takes the first two checks. The
    // length is written with its unused upper data bits set, which must be
    // dropped.
    task automatic test_rate_growth();
        set_registers(14'h3C01, 14'h3FFF);
        run_checks(120, 1, 0);
        finish_phase();
    endtask

    // Short bursts against ceilings around the growth steps and a random one.
    task automatic test_random_settings();
        logic [absc_pkg::CFG_DATA_W-1:0] ceil_word;
        repeat (3)
        begin
            unique case ($urandom_range(0, 5))
                0:       ceil_word = absc_pkg::CFG_DATA_W'(1);
                1:       ceil_word = absc_pkg::CFG_DATA_W'(9);
                2:       ceil_word = absc_pkg::CFG_DATA_W'(99);
                3:       ceil_word = absc_pkg::CFG_DATA_W'(100);
                4:       ceil_word = absc_pkg::CFG_DATA_W'(1000);
                default: ceil_word = absc_pkg::CFG_DATA_W'($urandom_range(1, 9999));
            endcase
            set_registers(absc_pkg::CFG_DATA_W'($urandom_range(1, 6)), ceil_word);
            run_checks(40, 3, 20);
            finish_phase();
        end
    endtask

    // A long burst of 60 checks. The result side holds off for a long
    // stretch at the start while checks keep coming, so the output register
    // fills and the block has to stall its check input.
    task automatic test_long_burst_backpressure();
        set_registers(absc_pkg::CFG_DATA_W'(60), absc_pkg::CFG_DATA_W'(9999));
        hold_off_req = 1'b1;
        run_checks(70, 2, 50);
        finish_phase();
    endtask

    // Closing stretch with both sides streaming at full rate.
    task automatic test_steady_stream();
        idling = 1'b0;
        set_registers(absc_pkg::CFG_DATA_W'(3), absc_pkg::CFG_DATA_W'(999));
        run_checks(30, 2, 20);
        finish_phase();
    endtask

    // Result side: random stalls of random length while idling is on, plus
    // the one long hold-off that the back-pressure test requests.
    initial
    begin : result_drain
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req     = 1'b0;
                result_ch.ready <= 1'b1;
            end
            else if (idling && stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Each accepted result word is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        check_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_decisions.size() == 0)
            begin
                $error("result word with no check waiting for it");
                mismatch_count++;
            end
            else
            begin
                want = pending_decisions.pop_front();
                if (result_ch.in_burst !== want.in_burst)
                begin
                    $error("in_burst: expected %0d, got %0d",
                           want.in_burst, result_ch.in_burst);
                    mismatch_count++;
                end
                if (result_ch.burst_started !== want.burst_started)
                begin
                    $error("burst_started: expected %0d, got %0d",
                           want.burst_started, result_ch.burst_started);
                    mismatch_count++;
                end
                if (result_ch.sampling_on !== want.sampling_on)
                begin
                    $error("sampling_on: expected %0d, got %0d",
                           want.sampling_on, result_ch.sampling_on);
                    mismatch_count++;
                end
                if (result_ch.site_rate !== want.site_rate)
                begin
                    $error("site_rate: expected %0d, got %0d",
                           want.site_rate, result_ch.site_rate);
                    mismatch_count++;
                end
                if (result_ch.total_checks !== want.total_checks)
                begin
                    $error("total_checks: expected %0d, got %0d",
                           want.total_checks, result_ch.total_checks);
                    mismatch_count++;
                end
                if (result_ch.sampled_checks !== want.sampled_checks)
                begin
                    $error("sampled_checks: expected %0d, got %0d",
                           want.sampled_checks, result_ch.sampled_checks);
                    mismatch_count++;
                end
            end
        end
    end

    // A hung handshake ends the run here.
    initial
    begin
        #RUN_LIMIT;
        $display("FAIL adaptive_burst_sampling_controller_unit");
        $finish;
    end

    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = absc_pkg::CFG_BURST_LENGTH;
        cfg_data              = '0;
        check_ch.valid        = 1'b0;
        check_ch.site_address = '0;
        mismatch_count        = 0;
        idling                = 1'b1;
        hold_off_req          = 1'b0;

        // The state copy starts from the reset state of the block.
        burst_len_setting = absc_pkg::LEN_RESET;
        ceiling_setting   = absc_pkg::CEIL_RESET;
        foreach (site_live[i])
            site_live[i] = 1'b0;
        burst_running   = 1'b0;
        burst_remaining = '0;
        checks_seen     = '0;
        checks_sampled  = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_ceiling_hold();
        test_tag_miss();
        test_zero_length();
        test_zero_ceiling();
        test_rate_growth();
        test_random_settings();
        test_long_burst_backpressure();
        test_steady_stream();

        if (mismatch_count == 0)
            $display("PASS adaptive_burst_sampling_controller_unit");
        else
            $display("FAIL adaptive_burst_sampling_controller_unit");
        $finish;
    end

endmodule
